>>> hdl/epm_pkg.sv
package epm_pkg;

  // Pool size must be a power of two: the rotating index math wraps by truncation.
  localparam int unsigned POOL_BYTES  = 32;
  localparam int unsigned IDX_W       = $clog2(POOL_BYTES);
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned READY_MIXES = 256;
  localparam int unsigned ROT_LEFT    = 3;
  localparam int unsigned TS_SHIFT    = 4;
  localparam int unsigned SEED_BYTES  = 8;
  localparam logic [7:0]  POS_MULT    = 8'h9E;

  typedef enum logic [2:0] {
    OP_SEED    = 3'd0,
    OP_MIX_DAT = 3'd1,
    OP_MIX_TS  = 3'd2,
    OP_MIX_IRQ = 3'd3,
    OP_GET     = 3'd4
  } epm_op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic [7:0]  irq_number;
    logic [63:0] timestamp;
    logic [7:0]  byte_index;
  } epm_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       ready_res;
    logic       status;
  } epm_out_t;

  typedef logic [7:0] pool_t [POOL_BYTES];

  function automatic logic [7:0] rotl_byte(input logic [7:0] v);
    rotl_byte = (v << ROT_LEFT) | (v >> (8 - ROT_LEFT));
  endfunction

  // One mix on a pool held so that entry 0 is the current write position.
  // The pool view advances by one entry, so the result is again index-aligned.
  function automatic pool_t mix_step(input pool_t p, input logic [7:0] b);
    pool_t      r;
    logic [7:0] v;
    v = rotl_byte(p[0] ^ b);
    for (int k = 0; k < POOL_BYTES - 1; k++) begin
      r[k] = p[k + 1];
    end
    r[0]              = p[1] ^ v;
    r[POOL_BYTES - 1] = v;
    return r;
  endfunction

endpackage

>>> hdl/epm_if.sv
interface epm_in_if
  import epm_pkg::*;
();
  logic    valid;
  logic    ready;
  epm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface epm_out_if
  import epm_pkg::*;
();
  logic     valid;
  logic     ready;
  epm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/entropy_pool_mixer.sv
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle; the single output register sets that figure,
// and a new item is taken whenever that register is empty or being drained.
// Reset (rst_ni low, asynchronous): pool cleared to zero, write index and mix
// count zeroed, output register empty.
module entropy_pool_mixer
  import epm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  epm_in_if.sink    in_i,
  epm_out_if.source out_o
);

  // Pool is stored rotated: pool_q[k] holds logical entry (write index + k).
  // Every mix then touches fixed entries 0 and 1 and shifts the whole row,
  // so only the get read uses a signal-chosen address.
  pool_t            pool_q, pool_d;
  pool_t            pool_m1;
  logic [IDX_W-1:0] widx_q, widx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_sum;
  logic             out_valid_q;
  epm_out_t         out_q, out_d;

  logic             accept;
  logic             pool_ready;
  logic             mix_en;
  logic             two_mix;
  logic [1:0]       n_mix;
  logic [7:0]       mix_b0, mix_b1;
  logic [IDX_W-1:0] sel_idx;
  logic [15:0]      pos_prod;
  logic [7:0]       get_byte;
  epm_op_e          op;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign op         = epm_op_e'(in_i.data.op);
  assign pool_ready = (cnt_q >= CNT_W'(READY_MIXES));

  // Get: map the logical position to the rotated storage by removing the write index.
  assign sel_idx  = in_i.data.byte_index[IDX_W-1:0] + in_i.data.timestamp[IDX_W-1:0] - widx_q;
  assign pos_prod = 16'(in_i.data.byte_index) * 16'(POS_MULT);
  assign get_byte = pool_q[sel_idx] ^ in_i.data.timestamp[TS_SHIFT +: 8] ^ pos_prod[7:0];

  // Decode which bytes are folded in and how many mixes this item performs.
  always_comb begin
    mix_en  = 1'b0;
    two_mix = 1'b0;
    mix_b0  = in_i.data.timestamp[7:0];
    mix_b1  = in_i.data.timestamp[15:8];
    unique case (op)
      OP_MIX_DAT: begin
        mix_en = 1'b1;
        mix_b0 = in_i.data.data_byte;
      end
      OP_MIX_TS: begin
        mix_en  = 1'b1;
        two_mix = 1'b1;
      end
      OP_MIX_IRQ: begin
        mix_en = 1'b1;
        mix_b0 = in_i.data.timestamp[7:0] ^ in_i.data.irq_number;
      end
      OP_GET: begin
        mix_en = pool_ready;
      end
      default: begin
      end
    endcase
  end

  assign n_mix = two_mix ? 2'd2 : (mix_en ? 2'd1 : 2'd0);

  // Next state: up to two cascaded mixes, or a seed load.
  always_comb begin
    pool_m1 = mix_step(pool_q, mix_b0);
    pool_d  = pool_q;
    widx_d  = widx_q;
    cnt_sum = cnt_q + CNT_W'(n_mix);
    cnt_d   = (cnt_sum > CNT_W'(READY_MIXES)) ? CNT_W'(READY_MIXES) : cnt_sum;
    if (op == OP_SEED) begin
      for (int k = 0; k < POOL_BYTES; k++) begin
        pool_d[k] = 8'h00;
      end
      for (int k = 0; k < SEED_BYTES; k++) begin
        pool_d[k % POOL_BYTES] = in_i.data.timestamp[8*k +: 8];
      end
      widx_d = '0;
      cnt_d  = '0;
    end else if (mix_en) begin
      pool_d = two_mix ? mix_step(pool_m1, mix_b1) : pool_m1;
      widx_d = widx_q + IDX_W'(n_mix);
    end
  end

  // Result: byte only for a granted get, refusal flagged for an early get.
  always_comb begin
    out_d.out_byte  = 8'h00;
    out_d.status    = 1'b0;
    out_d.ready_res = (cnt_d >= CNT_W'(READY_MIXES));
    if (op == OP_GET) begin
      if (pool_ready) begin
        out_d.out_byte = get_byte;
      end else begin
        out_d.status = 1'b1;
      end
    end
  end

  // Advance state on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < POOL_BYTES; k++) begin
        pool_q[k] <= 8'h00;
      end
      widx_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      pool_q <= pool_d;
      widx_q <= widx_d;
      cnt_q  <= cnt_d;
    end
  end

  // Output register: load on transfer in, drop once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

>>> hdl/epm_checker.sv
module epm_port_checker
  import epm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       ready_res_i,
  input logic       status_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A refused get never carries a byte and never reports ready.
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> out_byte_i == 8'h00 && !ready_res_i)
    else $error("refused get with data or readiness");

  // A seed transfer is answered next cycle with an empty, not-ready result.
  a_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_SEED |=>
      out_valid_i && !ready_res_i && !status_i && out_byte_i == 8'h00)
    else $error("seed result wrong");

  // A nonzero byte only comes from a granted get, so the pool is ready.
  a_byte_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_byte_i != 8'h00 |-> ready_res_i && !status_i)
    else $error("byte delivered from pool that is not ready");

endmodule

bind entropy_pool_mixer epm_port_checker u_epm_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.data.out_byte),
  .ready_res_i (out_o.data.ready_res),
  .status_i    (out_o.data.status)
);

>>> dv/epm_checker.sv
module epm_checker
  import epm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  epm_in_if    in_mon_i,
  epm_out_if   out_mon_i,
  output int   mismatches_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // Shadow of the pool state, advanced once per accepted input transfer.
  logic [7:0]       pool_q [POOL_BYTES];
  logic [IDX_W-1:0] wr_idx_q;
  logic [CNT_W-1:0] mix_cnt_q;
  epm_out_t         expected_q [$];
  int               fail_total;

  function automatic void fold_byte(input logic [7:0] b);
    logic [IDX_W-1:0] nxt;
    logic [7:0]       v;
    nxt = wr_idx_q + IDX_W'(1);
    v   = pool_q[wr_idx_q] ^ b;
    v   = {v[7-ROT_LEFT:0], v[7:8-ROT_LEFT]};
    pool_q[wr_idx_q] = v;
    pool_q[nxt]      = pool_q[nxt] ^ v;
    wr_idx_q         = nxt;
    if (mix_cnt_q < CNT_W'(READY_MIXES)) begin
      mix_cnt_q = mix_cnt_q + CNT_W'(1);
    end
  endfunction

  function automatic epm_out_t predict_outcome(input epm_in_t it);
    epm_out_t         r;
    logic [IDX_W-1:0] sel;
    logic [15:0]      weight;
    r = '0;
    case (it.op)
      OP_SEED: begin
        for (int k = 0; k < POOL_BYTES; k++) begin
          pool_q[k] = '0;
        end
        for (int k = 0; k < SEED_BYTES; k++) begin
          pool_q[k % POOL_BYTES] = it.timestamp[8*k +: 8];
        end
        wr_idx_q  = '0;
        mix_cnt_q = '0;
      end
      OP_MIX_DAT: fold_byte(it.data_byte);
      OP_MIX_TS: begin
        fold_byte(it.timestamp[7:0]);
        fold_byte(it.timestamp[15:8]);
      end
      OP_MIX_IRQ: fold_byte(it.timestamp[7:0] ^ it.irq_number);
      OP_GET: begin
        if (mix_cnt_q >= CNT_W'(READY_MIXES)) begin
          // pool size is a power of two, so the low bits give the modulo
          sel        = it.byte_index[IDX_W-1:0] + it.timestamp[IDX_W-1:0];
          weight     = 16'(it.byte_index) * 16'(POS_MULT);
          r.out_byte = pool_q[sel] ^ it.timestamp[TS_SHIFT +: 8] ^ weight[7:0];
          fold_byte(it.timestamp[7:0]);
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    r.ready_res = (mix_cnt_q >= CNT_W'(READY_MIXES));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    epm_out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < POOL_BYTES; k++) begin
        pool_q[k] = '0;
      end
      wr_idx_q  = '0;
      mix_cnt_q = '0;
      expected_q.delete();
      fail_total    = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // Retire the result first: the output is registered, so it belongs to an
      // earlier input, never to one taken at this same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_total < MAX_REPORTS) begin
            $display("%t: unexpected result out_byte=%02h ready_res=%0b status=%0b",
                     $realtime, out_mon_i.data.out_byte, out_mon_i.data.ready_res,
                     out_mon_i.data.status);
          end
          fail_total = fail_total + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_mon_i.data.out_byte !== want.out_byte ||
              out_mon_i.data.ready_res !== want.ready_res ||
              out_mon_i.data.status !== want.status) begin
            if (fail_total < MAX_REPORTS) begin
              $display("%t: mismatch expected out_byte=%02h ready_res=%0b status=%0b, %s",
                       $realtime, want.out_byte, want.ready_res, want.status, "got");
              $display("    out_byte=%02h ready_res=%0b status=%0b",
                       out_mon_i.data.out_byte, out_mon_i.data.ready_res,
                       out_mon_i.data.status);
            end
            fail_total = fail_total + 1;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_q.push_back(predict_outcome(in_mon_i.data));
      end
      mismatches_o  <= fail_total;
      outstanding_o <= expected_q.size();
    end
  end

endmodule

>>> dv/entropy_pool_mixer_tb.sv
module entropy_pool_mixer_tb;
  import epm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam real CLK_PERIOD   = 8.0;
  localparam int  RESET_CYCLES = 3;
  localparam int  RANDOM_ITEMS = 450;
  localparam int  MAX_WAIT     = 15;
  // Quiet cycles tolerated before the run is declared hung.
  localparam int  STALL_LIMIT  = 2000;
  // Cycles to keep watching after the last result, to catch stray extras.
  localparam int  TAIL_CYCLES  = 8;

  // Op codes the block does not decode; they must leave the state alone.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  epm_in_if  in_ch ();
  epm_out_if out_ch ();

  int mismatches;
  int outstanding;
  int quiet_cycles;

  // Stimulus bookkeeping: a rough count of mixes since the last seed, used
  // only to shape the op mix, and the number of decoded items sent so far.
  int mixes_done;
  int counted_items;
  int in_burst;
  int out_burst;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  entropy_pool_mixer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  epm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Draw the idle cycles before the next transfer. Now and then start a
  // burst of back-to-back transfers so that full-rate stretches occur too.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst = burst - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Favor the edge values so that every bit sees both 0 and 1 early.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {32'hFFFF_FFFF, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic epm_in_t item_of(input logic [2:0] op, input logic [7:0] dat,
                                      input logic [7:0] irq, input logic [63:0] ts,
                                      input logic [7:0] idx);
    epm_in_t it;
    it.op         = op;
    it.data_byte  = dat;
    it.irq_number = irq;
    it.timestamp  = ts;
    it.byte_index = idx;
    return it;
  endfunction

  // Randomize every field, even the ones the op ignores.
  function automatic epm_in_t rand_item(input logic [2:0] op);
    return item_of(op, pick_byte(), pick_byte(), pick_stamp(), pick_byte());
  endfunction

  function automatic logic [2:0] pick_spare_op();
    return 3'($urandom_range(OP_RSVD5, OP_RSVD7));
  endfunction

  // Filling phase: mostly mixes to reach readiness, with a few refused gets
  // and undecoded ops thrown in as noise.
  function automatic logic [2:0] pick_fill_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return OP_MIX_TS;
    if (r < 78) return OP_MIX_DAT;
    if (r < 92) return OP_MIX_IRQ;
    if (r < 96) return OP_GET;
    return pick_spare_op();
  endfunction

  // Ready phase: gets interleaved with mixes; a rare reseed breaks the run
  // and drops the pool back to not-ready.
  function automatic logic [2:0] pick_ready_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_GET;
    if (r < 55) return OP_MIX_TS;
    if (r < 70) return OP_MIX_DAT;
    if (r < 85) return OP_MIX_IRQ;
    if (r < 94) return pick_spare_op();
    if (r < 96) return OP_SEED;
    return OP_GET;
  endfunction

  // Send one item: idle for the drawn gap, hold valid and the payload, and
  // return once the transfer has taken place.
  task automatic issue(input epm_in_t it);
    int gap;
    case (it.op)
      OP_SEED:                mixes_done = 0;
      OP_MIX_DAT, OP_MIX_IRQ: mixes_done = mixes_done + 1;
      OP_MIX_TS:              mixes_done = mixes_done + 2;
      OP_GET: begin
        if (mixes_done >= READY_MIXES) mixes_done = mixes_done + 1;
      end
      default: ;
    endcase
    if (it.op <= OP_GET) counted_items = counted_items + 1;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Result side: stall for a drawn number of cycles, then accept one result.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    out_burst = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Hang detection: count cycles in which neither channel transfers.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    mixes_done    = 0;
    counted_items = 0;
    in_burst      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: refused gets on a fresh and on a seeded pool, every
    // undecoded op, seeds with edge timestamps, and each mix source at its
    // field extremes.
    issue(item_of(OP_GET,     8'h00, 8'h00, '1, 8'hFF));
    issue(item_of(OP_RSVD5,   8'hFF, 8'hFF, '1, 8'hFF));
    issue(item_of(OP_SEED,    8'h00, 8'h00, '1, 8'h00));
    issue(item_of(OP_MIX_DAT, 8'h00, 8'h00, '0, 8'h00));
    issue(item_of(OP_MIX_DAT, 8'hFF, 8'h00, '0, 8'h00));
    issue(item_of(OP_MIX_IRQ, 8'h00, 8'hFF, 64'hFFFF_FFFF_FFFF_FF00, 8'h00));
    issue(item_of(OP_MIX_IRQ, 8'h00, 8'h00, '1, 8'h00));
    issue(item_of(OP_MIX_IRQ, 8'h00, 8'hFF, '1, 8'h00));
    issue(item_of(OP_MIX_TS,  8'h00, 8'h00, '1, 8'h00));
    issue(item_of(OP_MIX_TS,  8'h00, 8'h00, '0, 8'h00));
    issue(item_of(OP_GET,     8'h00, 8'h00, '0, 8'h00));
    issue(item_of(OP_RSVD6,   8'h00, 8'h00, '0, 8'h00));
    issue(item_of(OP_RSVD7,   8'hFF, 8'h00, '1, 8'hFF));
    issue(item_of(OP_SEED,    8'h00, 8'h00, '0, 8'h00));
    issue(item_of(OP_MIX_DAT, 8'hA5, 8'h5A, 64'h0123_4567_89AB_CDEF, 8'h3C));
    issue(item_of(OP_SEED,    8'h00, 8'h00, 64'h8040_2010_0804_0201, 8'h00));
    issue(item_of(OP_MIX_TS,  8'h00, 8'h00, 64'hFEDC_BA98_7654_3210, 8'h00));
    issue(item_of(OP_GET,     8'hFF, 8'hFF, '1, 8'h80));

    // Random part, in episodes: reseed, fill until ready, then run gets and
    // mixes on the ready pool, which also drives the mix count into saturation.
    // Stop as soon as the item budget is spent, even inside an episode.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      issue(rand_item(OP_SEED));
      while (mixes_done < READY_MIXES && counted_items < RANDOM_ITEMS) begin
        issue(rand_item(pick_fill_op()));
      end
      repeat ($urandom_range(60, 140)) begin
        if (counted_items < RANDOM_ITEMS) issue(rand_item(pick_ready_op()));
      end
    end
    in_ch.valid <= 1'b0;

    // Let the last transfer reach the checker's count, then drain.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/epm_pkg.sv
hdl/epm_if.sv
hdl/entropy_pool_mixer.sv
hdl/epm_checker.sv
dv/epm_checker.sv
dv/entropy_pool_mixer_tb.sv
